// ===== hdl/sdst_pkg.sv =====
// sdst_pkg: shared types and constants for the sd spi sector transfer engine
// no dependencies
package sdst_pkg;

    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_EXCHANGE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_NO_RESP   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_TOKEN     = 3'd4;
    localparam logic [2:0] ST_CRC       = 3'd5;
    localparam logic [2:0] ST_WREJECT   = 3'd6;
    localparam logic [2:0] ST_BUSY      = 3'd7;

    localparam logic [2:0] CFG_BLOCK_ADDR = 3'd0;
    localparam logic [2:0] CFG_READY_LIM  = 3'd1;
    localparam logic [2:0] CFG_RESP_LIM   = 3'd2;
    localparam logic [2:0] CFG_TOKEN_LIM  = 3'd3;
    localparam logic [2:0] CFG_BUSY_LIM   = 3'd4;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;
    localparam logic [7:0] CMD17_BYTE = 8'h51;
    localparam logic [7:0] CMD24_BYTE = 8'h58;
    localparam logic [7:0] FRAME_END  = 8'h01;
    localparam logic [4:0] DRESP_MASK = 5'h1F;
    localparam logic [4:0] DRESP_OK   = 5'h05;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef enum logic [14:0] {
        PH_IDLE    = 15'h0001,
        PH_READY   = 15'h0002,
        PH_CMD     = 15'h0004,
        PH_RESP    = 15'h0008,
        PH_TOKEN   = 15'h0010,
        PH_RDATA   = 15'h0020,
        PH_RCRC_HI = 15'h0040,
        PH_RCRC_LO = 15'h0080,
        PH_WREADY  = 15'h0100,
        PH_WTOKEN  = 15'h0200,
        PH_WDATA   = 15'h0400,
        PH_WCRC_HI = 15'h0800,
        PH_WCRC_LO = 15'h1000,
        PH_WRESP   = 15'h2000,
        PH_BUSY    = 15'h4000
    } t_phase;

    typedef struct packed {
        logic       block_addressing;
        logic [9:0] ready_lim;
        logic [9:0] resp_lim;
        logic [11:0] token_lim;
        logic [15:0] busy_lim;
    } t_cfg;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       need_wb;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       done;
        logic [2:0] status;
        logic [7:0] resp;
    } t_result;

endpackage

// ===== hdl/sdst_crc16.sv =====
// sdst_crc16: one byte step of crc16 xmodem, combinational
// depends on sdst_pkg
module sdst_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ sdst_pkg::CRC_POLY;
            else       c = {c[14:0], 1'b0};
        end
        o_crc = c;
    end
endmodule

// ===== hdl/sdst_engine.sv =====
// sdst_engine: transfer sequencer, one item processed per cycle while i_go is high
// depends on sdst_pkg and sdst_crc16
module sdst_engine #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [1:0]            i_cmd,
    input  logic [31:0]           i_block_number,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_write_byte,
    input  sdst_pkg::t_cfg        i_cfg,
    output sdst_pkg::t_result     o_res
);
    localparam int CW = $clog2(SECTOR_BYTES + 1);

    sdst_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0] r_poll, n_poll, r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi, r_resp, n_resp;
    logic [31:0] r_addr, n_addr;
    logic        r_wr, n_wr;
    logic [7:0]  crc_in;
    logic [15:0] crc_out, poll_inc;
    sdst_pkg::t_result res;

    sdst_crc16 u_crc (.i_crc(r_crc), .i_data(crc_in), .o_crc(crc_out));

    assign crc_in   = (r_phase == sdst_pkg::PH_RDATA) ? i_rx_byte : i_write_byte;
    assign poll_inc = (r_poll == 16'hFFFF) ? r_poll : r_poll + 16'd1;

    function automatic logic [7:0] frame(input logic [CW-1:0] idx, input logic wr,
                                         input logic [31:0] a);
        case (idx)
            CW'(0):  frame = wr ? sdst_pkg::CMD24_BYTE : sdst_pkg::CMD17_BYTE;
            CW'(1):  frame = a[31:24];
            CW'(2):  frame = a[23:16];
            CW'(3):  frame = a[15:8];
            CW'(4):  frame = a[7:0];
            default: frame = sdst_pkg::FRAME_END;
        endcase
    endfunction

    always_comb begin
        logic fin;
        logic txv;
        logic [7:0] tx;
        fin = 1'b0; txv = 1'b0; tx = 8'h00;
        n_phase = r_phase; n_cnt = r_cnt; n_poll = r_poll; n_crc = r_crc;
        n_crc_hi = r_crc_hi; n_resp = r_resp; n_addr = r_addr; n_wr = r_wr;
        res = '0;
        if (i_cmd == sdst_pkg::CMD_READ || i_cmd == sdst_pkg::CMD_WRITE) begin
            if (r_phase == sdst_pkg::PH_IDLE) begin
                n_wr = i_cmd[0];
                n_addr = i_cfg.block_addressing ? i_block_number
                                                : {i_block_number[22:0], 9'd0};
                n_phase = sdst_pkg::PH_READY;
                n_poll = '0; n_cnt = '0; n_crc = '0;
                txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
            end
        end else if (i_cmd == sdst_pkg::CMD_EXCHANGE) begin
            case (r_phase)
                sdst_pkg::PH_READY, sdst_pkg::PH_WREADY: begin
                    if (i_rx_byte == sdst_pkg::BYTE_IDLE) begin
                        txv = 1'b1;
                        if (r_phase == sdst_pkg::PH_READY) begin
                            n_phase = sdst_pkg::PH_CMD; n_cnt = CW'(1);
                            tx = frame(CW'(0), r_wr, r_addr);
                        end else begin
                            n_phase = sdst_pkg::PH_WTOKEN; n_crc = '0; n_cnt = '0;
                            tx = sdst_pkg::BYTE_TOKEN; res.need_wb = 1'b1;
                        end
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= {6'd0, i_cfg.ready_lim}) begin
                            fin = 1'b1; res.status = sdst_pkg::ST_NOT_READY;
                        end else begin
                            txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                        end
                    end
                end
                sdst_pkg::PH_CMD: begin
                    txv = 1'b1;
                    if (r_cnt < CW'(6)) begin
                        tx = frame(r_cnt, r_wr, r_addr); n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_phase = sdst_pkg::PH_RESP; n_poll = '0;
                        tx = sdst_pkg::BYTE_IDLE;
                    end
                end
                sdst_pkg::PH_RESP: begin
                    if (!i_rx_byte[7]) begin
                        n_resp = i_rx_byte; n_poll = '0;
                        if (i_rx_byte != 8'h00) begin
                            fin = 1'b1; res.status = sdst_pkg::ST_REJECTED;
                        end else begin
                            n_phase = r_wr ? sdst_pkg::PH_WREADY : sdst_pkg::PH_TOKEN;
                            txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                        end
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= {6'd0, i_cfg.resp_lim}) begin
                            n_resp = i_rx_byte; fin = 1'b1;
                            res.status = sdst_pkg::ST_NO_RESP;
                        end else begin
                            txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                        end
                    end
                end
                sdst_pkg::PH_TOKEN: begin
                    if (i_rx_byte == sdst_pkg::BYTE_TOKEN) begin
                        n_phase = sdst_pkg::PH_RDATA; n_cnt = '0; n_crc = '0;
                        txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                    end else if (i_rx_byte != sdst_pkg::BYTE_IDLE) begin
                        fin = 1'b1; res.status = sdst_pkg::ST_TOKEN;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= {4'd0, i_cfg.token_lim}) begin
                            fin = 1'b1; res.status = sdst_pkg::ST_TOKEN;
                        end else begin
                            txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                        end
                    end
                end
                sdst_pkg::PH_RDATA: begin
                    res.rd_valid = 1'b1; res.rd_byte = i_rx_byte;
                    n_crc = crc_out; n_cnt = r_cnt + CW'(1);
                    if (n_cnt >= CW'(SECTOR_BYTES)) n_phase = sdst_pkg::PH_RCRC_HI;
                    txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                end
                sdst_pkg::PH_RCRC_HI: begin
                    n_crc_hi = i_rx_byte; n_phase = sdst_pkg::PH_RCRC_LO;
                    txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                end
                sdst_pkg::PH_RCRC_LO: begin
                    fin = 1'b1;
                    res.status = ({r_crc_hi, i_rx_byte} == r_crc) ? sdst_pkg::ST_OK
                                                                 : sdst_pkg::ST_CRC;
                end
                sdst_pkg::PH_WTOKEN, sdst_pkg::PH_WDATA: begin
                    txv = 1'b1;
                    if (r_cnt < CW'(SECTOR_BYTES)) begin
                        tx = i_write_byte; n_crc = crc_out; n_cnt = r_cnt + CW'(1);
                        n_phase = sdst_pkg::PH_WDATA;
                        res.need_wb = (n_cnt < CW'(SECTOR_BYTES));
                    end else begin
                        n_phase = sdst_pkg::PH_WCRC_HI; tx = r_crc[15:8];
                    end
                end
                sdst_pkg::PH_WCRC_HI: begin
                    n_phase = sdst_pkg::PH_WCRC_LO; txv = 1'b1; tx = r_crc[7:0];
                end
                sdst_pkg::PH_WCRC_LO: begin
                    n_phase = sdst_pkg::PH_WRESP; txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                end
                sdst_pkg::PH_WRESP: begin
                    n_resp = i_rx_byte;
                    if ((i_rx_byte[4:0] & sdst_pkg::DRESP_MASK) != sdst_pkg::DRESP_OK) begin
                        fin = 1'b1; res.status = sdst_pkg::ST_WREJECT;
                    end else begin
                        n_phase = sdst_pkg::PH_BUSY; n_poll = '0;
                        txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                    end
                end
                sdst_pkg::PH_BUSY: begin
                    if (i_rx_byte == sdst_pkg::BYTE_IDLE) begin
                        fin = 1'b1; res.status = sdst_pkg::ST_OK;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= i_cfg.busy_lim) begin
                            fin = 1'b1; res.status = sdst_pkg::ST_BUSY;
                        end else begin
                            txv = 1'b1; tx = sdst_pkg::BYTE_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (fin) begin
            n_phase = sdst_pkg::PH_IDLE; res.done = 1'b1;
            txv = 1'b0; tx = 8'h00; res.need_wb = 1'b0;
        end else begin
            res.status = sdst_pkg::ST_OK;
        end
        res.tx_valid = txv; res.tx_byte = tx;
        res.cs_active = (n_phase != sdst_pkg::PH_IDLE);
        res.resp = n_resp;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdst_pkg::PH_IDLE; r_cnt <= '0; r_poll <= '0; r_crc <= '0;
            r_crc_hi <= '0; r_addr <= '0; r_wr <= 1'b0; r_resp <= '0;
        end else if (i_go) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_poll <= n_poll; r_crc <= n_crc;
            r_crc_hi <= n_crc_hi; r_addr <= n_addr; r_wr <= n_wr; r_resp <= n_resp;
        end
    end
endmodule

// ===== hdl/sd_spi_sector_transfer.sv =====
// sd_spi_sector_transfer: sd card spi mode single block read and write host engine
// throughput: one item per cycle while o_stall is low
// a one-entry skid behind the output register keeps intake running while output stalls, until it fills
// reset: synchronous active low, sequencer idle, configuration registers at their defaults, output valid flags cleared
module sd_spi_sector_transfer #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_block_number,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_write_byte,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_chip_select_active,
    output logic        o_need_write_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [7:0]  o_response_code
);
    sdst_pkg::t_cfg    r_cfg;
    sdst_pkg::t_result res, r_out, r_skid;
    logic              r_out_v, r_skid_v, go;

    // take an item whenever the skid entry is free
    assign o_stall = r_skid_v;
    assign go      = i_valid && !r_skid_v;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_addressing <= 1'b0;
            r_cfg.ready_lim <= 10'd501;
            r_cfg.resp_lim  <= 10'd500;
            r_cfg.token_lim <= 12'd1000;
            r_cfg.busy_lim  <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdst_pkg::CFG_BLOCK_ADDR: r_cfg.block_addressing <= i_cfg_data[0];
                sdst_pkg::CFG_READY_LIM:  r_cfg.ready_lim <= i_cfg_data[9:0];
                sdst_pkg::CFG_RESP_LIM:   r_cfg.resp_lim  <= i_cfg_data[9:0];
                sdst_pkg::CFG_TOKEN_LIM:  r_cfg.token_lim <= i_cfg_data[11:0];
                sdst_pkg::CFG_BUSY_LIM:   r_cfg.busy_lim  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sdst_engine #(.SECTOR_BYTES(SECTOR_BYTES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_cmd(i_cmd),
        .i_block_number(i_block_number), .i_rx_byte(i_rx_byte),
        .i_write_byte(i_write_byte), .i_cfg(r_cfg), .o_res(res)
    );

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || !i_stall) begin
                if (r_skid_v) begin
                    r_out_v <= 1'b1; r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= go;
                end
            end else if (go) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (go) begin
            r_skid <= res;
        end
    end

    assign o_valid              = r_out_v;
    assign o_tx_valid           = r_out.tx_valid;
    assign o_tx_byte            = r_out.tx_byte;
    assign o_chip_select_active = r_out.cs_active;
    assign o_need_write_byte    = r_out.need_wb;
    assign o_read_valid         = r_out.rd_valid;
    assign o_read_byte          = r_out.rd_byte;
    assign o_done_res           = r_out.done;
    assign o_status             = r_out.status;
    assign o_response_code      = r_out.resp;
endmodule

// ===== hdl/sdst_checker.sv =====
// sdst_checker: port level assertions for sd_spi_sector_transfer
// depends on sdst_pkg and the top level ports, attached by bind
module sdst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_done_res,
    input logic [2:0] o_status,
    input logic       o_chip_select_active
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_byte))
        else $error("stalled item changed");
    a_done_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_chip_select_active && !o_tx_valid)
        else $error("finished item keeps chip select");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == sdst_pkg::ST_OK)
        else $error("status without finish");
    a_txz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'h00)
        else $error("tx byte without tx valid");
endmodule

bind sd_spi_sector_transfer sdst_checker u_sdst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_tx_valid(o_tx_valid), .o_tx_byte(o_tx_byte), .o_done_res(o_done_res),
    .o_status(o_status), .o_chip_select_active(o_chip_select_active)
);

// ===== verif/sd_spi_sector_transfer_chk.sv =====
// sd_spi_sector_transfer_chk: predicts and checks every result item of the sector engine
// depends on sdst_pkg
`timescale 1ns / 1ps
module sd_spi_sector_transfer_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_block_number,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_write_byte,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  sdst_pkg::t_result i_res,
    output int                o_fail_count,
    output int                o_pending
);
    localparam int SECTOR = 512;

    // engine state
    sdst_pkg::t_phase ph;
    logic [9:0]  nbytes;
    logic [15:0] npolls;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    logic [31:0] addr;
    logic        wr;
    logic [7:0]  resp;
    // registers
    logic        blk_mode;
    logic [9:0]  rdy_lim, r1_lim;
    logic [11:0] tok_lim;
    logic [15:0] bsy_lim;

    sdst_pkg::t_result expected_results[$];

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
        c = c ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ sdst_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    // true once the poll budget is used up
    function automatic logic polls_exhausted(logic [15:0] lim);
        if (npolls != 16'hFFFF) npolls++;
        return npolls >= lim;
    endfunction

    function automatic logic [7:0] frame_at(int k);
        case (k)
            0: return wr ? sdst_pkg::CMD24_BYTE : sdst_pkg::CMD17_BYTE;
            1: return addr[31:24];
            2: return addr[23:16];
            3: return addr[15:8];
            4: return addr[7:0];
            default: return sdst_pkg::FRAME_END;
        endcase
    endfunction

    task automatic predict_exchange(logic [1:0] c, logic [31:0] bn, logic [7:0] rx,
                                    logic [7:0] wb);
        sdst_pkg::t_result r;
        logic    fin;
        r = '0;
        fin = 1'b0;
        if (c == sdst_pkg::CMD_READ || c == sdst_pkg::CMD_WRITE) begin
            if (ph == sdst_pkg::PH_IDLE) begin
                wr = (c == sdst_pkg::CMD_WRITE);
                addr = blk_mode ? bn : (bn << 9);
                ph = sdst_pkg::PH_READY;
                npolls = 0; nbytes = 0; crc = 0;
                r.tx_valid = 1; r.tx_byte = sdst_pkg::BYTE_IDLE;
            end
        end else if (c == sdst_pkg::CMD_EXCHANGE && ph != sdst_pkg::PH_IDLE) begin
            r.tx_valid = 1; r.tx_byte = sdst_pkg::BYTE_IDLE;
            case (ph)
                sdst_pkg::PH_READY: begin
                    if (rx == sdst_pkg::BYTE_IDLE) begin
                        ph = sdst_pkg::PH_CMD; nbytes = 1; r.tx_byte = frame_at(0);
                    end else if (polls_exhausted({6'd0, rdy_lim})) begin
                        fin = 1; r.status = sdst_pkg::ST_NOT_READY;
                    end
                end
                sdst_pkg::PH_CMD: begin
                    if (nbytes < 6) begin
                        r.tx_byte = frame_at(nbytes); nbytes++;
                    end else begin
                        ph = sdst_pkg::PH_RESP; npolls = 0;
                    end
                end
                sdst_pkg::PH_RESP: begin
                    if (!rx[7]) begin
                        resp = rx; npolls = 0;
                        if (rx != 0) begin
                            fin = 1; r.status = sdst_pkg::ST_REJECTED;
                        end else ph = wr ? sdst_pkg::PH_WREADY : sdst_pkg::PH_TOKEN;
                    end else if (polls_exhausted({6'd0, r1_lim})) begin
                        resp = rx; fin = 1; r.status = sdst_pkg::ST_NO_RESP;
                    end
                end
                sdst_pkg::PH_TOKEN: begin
                    if (rx == sdst_pkg::BYTE_TOKEN) begin
                        ph = sdst_pkg::PH_RDATA; nbytes = 0; crc = 0;
                    end else if (rx != sdst_pkg::BYTE_IDLE
                                 || polls_exhausted({4'd0, tok_lim})) begin
                        fin = 1; r.status = sdst_pkg::ST_TOKEN;
                    end
                end
                sdst_pkg::PH_RDATA: begin
                    r.rd_valid = 1; r.rd_byte = rx;
                    crc = crc_next(crc, rx);
                    nbytes++;
                    if (nbytes >= SECTOR) ph = sdst_pkg::PH_RCRC_HI;
                end
                sdst_pkg::PH_RCRC_HI: begin
                    crc_hi = rx; ph = sdst_pkg::PH_RCRC_LO;
                end
                sdst_pkg::PH_RCRC_LO: begin
                    fin = 1;
                    r.status = ({crc_hi, rx} == crc) ? sdst_pkg::ST_OK : sdst_pkg::ST_CRC;
                end
                sdst_pkg::PH_WREADY: begin
                    if (rx == sdst_pkg::BYTE_IDLE) begin
                        ph = sdst_pkg::PH_WTOKEN; crc = 0; nbytes = 0;
                        r.tx_byte = sdst_pkg::BYTE_TOKEN; r.need_wb = 1;
                    end else if (polls_exhausted({6'd0, rdy_lim})) begin
                        fin = 1; r.status = sdst_pkg::ST_NOT_READY;
                    end
                end
                sdst_pkg::PH_WTOKEN, sdst_pkg::PH_WDATA: begin
                    if (nbytes < SECTOR) begin
                        r.tx_byte = wb; crc = crc_next(crc, wb);
                        nbytes++; ph = sdst_pkg::PH_WDATA;
                        r.need_wb = (nbytes < SECTOR);
                    end else begin
                        ph = sdst_pkg::PH_WCRC_HI; r.tx_byte = crc[15:8];
                    end
                end
                sdst_pkg::PH_WCRC_HI: begin
                    ph = sdst_pkg::PH_WCRC_LO; r.tx_byte = crc[7:0];
                end
                sdst_pkg::PH_WCRC_LO: ph = sdst_pkg::PH_WRESP;
                sdst_pkg::PH_WRESP: begin
                    resp = rx;
                    if ((rx[4:0] & sdst_pkg::DRESP_MASK) != sdst_pkg::DRESP_OK) begin
                        fin = 1; r.status = sdst_pkg::ST_WREJECT;
                    end else begin
                        ph = sdst_pkg::PH_BUSY; npolls = 0;
                    end
                end
                sdst_pkg::PH_BUSY: begin
                    if (rx == sdst_pkg::BYTE_IDLE) begin
                        fin = 1; r.status = sdst_pkg::ST_OK;
                    end else if (polls_exhausted(bsy_lim)) begin
                        fin = 1; r.status = sdst_pkg::ST_BUSY;
                    end
                end
                default: ph = sdst_pkg::PH_IDLE;
            endcase
        end
        if (fin) begin
            ph = sdst_pkg::PH_IDLE; r.done = 1;
            r.tx_valid = 0; r.tx_byte = 0; r.need_wb = 0;
        end else r.status = sdst_pkg::ST_OK;
        r.cs_active = (ph != sdst_pkg::PH_IDLE);
        r.resp = resp;
        expected_results.push_back(r);
    endtask

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        sdst_pkg::t_result e;
        if (!i_rst_n) begin
            ph = sdst_pkg::PH_IDLE;
            nbytes = 0; npolls = 0; crc = 0; crc_hi = 0; addr = 0; wr = 0; resp = 0;
            blk_mode = 0; rdy_lim = 501; r1_lim = 500; tok_lim = 1000; bsy_lim = 16'hFFFF;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdst_pkg::CFG_BLOCK_ADDR: blk_mode = i_cfg_data[0];
                    sdst_pkg::CFG_READY_LIM:  rdy_lim = i_cfg_data[9:0];
                    sdst_pkg::CFG_RESP_LIM:   r1_lim = i_cfg_data[9:0];
                    sdst_pkg::CFG_TOKEN_LIM:  tok_lim = i_cfg_data[11:0];
                    sdst_pkg::CFG_BUSY_LIM:   bsy_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    compare_field("tx_valid", e.tx_valid, i_res.tx_valid);
                    compare_field("tx_byte", e.tx_byte, i_res.tx_byte);
                    compare_field("chip_select_active", e.cs_active, i_res.cs_active);
                    compare_field("need_write_byte", e.need_wb, i_res.need_wb);
                    compare_field("read_valid", e.rd_valid, i_res.rd_valid);
                    compare_field("read_byte", e.rd_byte, i_res.rd_byte);
                    compare_field("done_res", e.done, i_res.done);
                    compare_field("status", e.status, i_res.status);
                    compare_field("response_code", e.resp, i_res.resp);
                end
            end
            if (i_valid && !i_stall_in)
                predict_exchange(i_cmd, i_block_number, i_rx_byte, i_write_byte);
        end
        o_pending <= expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        ph = sdst_pkg::PH_IDLE;
    end
endmodule

// ===== verif/sd_spi_sector_transfer_tb.sv =====
// sd_spi_sector_transfer_tb: stimulus and verdict for the sd spi sector engine
// depends on sdst_pkg, sd_spi_sector_transfer and sd_spi_sector_transfer_chk
`timescale 1ns / 1ps
module sd_spi_sector_transfer_tb;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic [1:0]        i_cmd = sdst_pkg::CMD_EXCHANGE;
    logic [31:0]       i_block_number = 0;
    logic [7:0]        i_rx_byte = 0;
    logic [7:0]        i_write_byte = 0;
    logic              i_cfg_we = 0;
    logic [2:0]        i_cfg_index = sdst_pkg::CFG_BLOCK_ADDR;
    logic [15:0]       i_cfg_data = 0;
    logic              o_valid;
    logic              i_stall = 0;
    sdst_pkg::t_result res;
    int                fail_count, pending;
    int                items_sent = 0;
    bit                sink_hold = 0;   // long receiver hold-off requested
    bit                sink_on = 0;

    always #6 i_clk = ~i_clk;

    sd_spi_sector_transfer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_block_number(i_block_number), .i_rx_byte(i_rx_byte),
        .i_write_byte(i_write_byte), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .i_stall(i_stall),
        .o_tx_valid(res.tx_valid), .o_tx_byte(res.tx_byte),
        .o_chip_select_active(res.cs_active), .o_need_write_byte(res.need_wb),
        .o_read_valid(res.rd_valid), .o_read_byte(res.rd_byte), .o_done_res(res.done),
        .o_status(res.status), .o_response_code(res.resp)
    );

    sd_spi_sector_transfer_chk checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_cmd(i_cmd), .i_block_number(i_block_number), .i_rx_byte(i_rx_byte),
        .i_write_byte(i_write_byte), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_res(res), .o_fail_count(fail_count), .o_pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one item: hold valid until accepted, then maybe an idle gap
    task automatic send_item(logic [1:0] c, logic [31:0] bn, logic [7:0] rx,
                             logic [7:0] wb);
        int g;
        i_valid <= 1; i_cmd <= c; i_block_number <= bn;
        i_rx_byte <= rx; i_write_byte <= wb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            i_cmd <= 2'($urandom); i_block_number <= $urandom; i_rx_byte <= 8'($urandom);
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic xchg(logic [7:0] rx);
        send_item(sdst_pkg::CMD_EXCHANGE, $urandom, rx, 8'($urandom));
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [7:0] non_idle();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == sdst_pkg::BYTE_IDLE) b = 8'h00;
        return b;
    endfunction

    // a well-formed transfer with random content; err picks where it breaks
    task automatic transfer(bit wr, int err, int rdy_polls, bit good_crc);
        logic [15:0] c;
        logic [7:0]  b;
        int          n;
        c = 0;
        send_item(wr ? sdst_pkg::CMD_WRITE : sdst_pkg::CMD_READ, $urandom,
                  8'($urandom), 8'($urandom));
        if (err == 1) begin
            repeat (4) xchg(non_idle());
            return;
        end
        repeat (rdy_polls) xchg(non_idle());
        xchg(sdst_pkg::BYTE_IDLE);
        repeat (6) xchg(8'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) xchg(8'h80 | 8'($urandom));
        if (err == 2) begin
            repeat (10) xchg(8'h80 | 8'($urandom));
            return;
        end
        if (err == 3) begin
            xchg(8'($urandom_range(1, 127)));
            return;
        end
        xchg(8'h00);
        if (!wr) begin
            repeat ($urandom_range(0, 3)) xchg(sdst_pkg::BYTE_IDLE);
            if (err == 4) begin
                xchg($urandom_range(0, 1) ? 8'h12 : 8'h00);
                return;
            end
            xchg(sdst_pkg::BYTE_TOKEN);
            for (int i = 0; i < 512; i++) begin
                b = 8'($urandom);
                for (int k = 0; k < 8; k++) begin
                    c = c ^ ({8'd0, b[7-k]} << 15);
                    c = c[15] ? ((c << 1) ^ sdst_pkg::CRC_POLY) : (c << 1);
                end
                xchg(b);
            end
            if (!good_crc) c = c ^ 16'(1 << $urandom_range(0, 15));
            xchg(c[15:8]);
            xchg(c[7:0]);
        end else begin
            repeat ($urandom_range(0, 2)) xchg(non_idle());
            xchg(sdst_pkg::BYTE_IDLE);
            for (int i = 0; i < 513; i++) xchg(8'($urandom));
            xchg(8'($urandom)); xchg(8'($urandom));
            if (err == 6) begin
                xchg({3'($urandom), 5'h0B});
                return;
            end
            xchg({3'($urandom), sdst_pkg::DRESP_OK});
            if (err == 7) begin
                repeat (55) xchg(non_idle());
                return;
            end
            repeat ($urandom_range(0, 5)) xchg(8'h00);
            xchg(sdst_pkg::BYTE_IDLE);
        end
    endtask

    // receiver stall: random gaps, or one long hold-off on request
    always @(posedge i_clk) begin
        int g;
        if (!sink_on) i_stall <= 0;
        else if (sink_hold) begin
            i_stall <= 1;
            repeat (200) @(posedge i_clk);
            sink_hold = 0;
            i_stall <= 0;
        end else begin
            g = gap_len();
            if (g > 0) begin
                i_stall <= 1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        sink_on = 1;

        // directed: extremes, ignored items and a rejected command, at small limits
        write_reg(sdst_pkg::CFG_RESP_LIM, 16'd5);
        write_reg(sdst_pkg::CFG_TOKEN_LIM, 16'd4);
        xchg(8'hFF);                                      // exchange while idle
        send_item(2'd3, 32'hFFFF_FFFF, 8'h00, 8'hFF);     // unused command code
        send_item(sdst_pkg::CMD_READ, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        send_item(sdst_pkg::CMD_WRITE, 32'h0, 8'h00, 8'hFF); // start while busy
        xchg(8'h00); xchg(8'hFF);
        repeat (6) xchg(8'hAA);
        xchg(8'h01);                                      // rejected command
        xchg(8'hFF);                                      // idle again, ignored
        drain();

        // phases through register settings, extremes included
        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            write_reg(sdst_pkg::CFG_BLOCK_ADDR, 16'(ph_i[0]));
            write_reg(sdst_pkg::CFG_READY_LIM,
                      ph_i == 0 ? 16'd1 : ph_i == 1 ? 16'd1023 : 16'd3);
            write_reg(sdst_pkg::CFG_RESP_LIM,
                      ph_i == 2 ? 16'd1023 : ph_i == 0 ? 16'd8 : 16'd1);
            write_reg(sdst_pkg::CFG_TOKEN_LIM,
                      ph_i == 3 ? 16'd4095 : ph_i == 0 ? 16'd8 : 16'd2);
            write_reg(sdst_pkg::CFG_BUSY_LIM,
                      ph_i == 1 ? 16'd65535 : ph_i == 0 ? 16'd1 : 16'd50);
            if (ph_i == 3) write_reg(sdst_pkg::CFG_READY_LIM, 16'd0);
            for (int t = 0; t < 4; t++) begin
                int e;
                bit w;
                if (t < 3) begin
                    // short transfers that break before the data phase
                    e = $urandom_range(1, 4);
                    if (ph_i == 1 && e == 1) e = 2;
                    if (ph_i == 2 && e == 2) e = 3;
                    w = (e == 4) ? 1'b0 : 1'($urandom_range(0, 1));
                    transfer(w, e, $urandom_range(0, 2), 1'b1);
                end else if (ph_i == 0) begin
                    // full read under a long receiver hold-off
                    sink_hold = 1;
                    transfer(1'b0, 0, 0, 1'($urandom_range(0, 3) != 0));
                end else if (ph_i == 2) begin
                    // full write, ending ok, rejected or busy timeout
                    e = $urandom_range(0, 2);
                    e = (e == 1) ? 6 : (e == 2) ? 7 : 0;
                    transfer(1'b1, e, $urandom_range(0, 2), 1'b1);
                end
                if ($urandom_range(0, 3) == 0) xchg(8'($urandom));  // stray exchange
            end
            drain();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/sdst_pkg.sv
hdl/sdst_crc16.sv
hdl/sdst_engine.sv
hdl/sd_spi_sector_transfer.sv
hdl/sdst_checker.sv
verif/sd_spi_sector_transfer_chk.sv
verif/sd_spi_sector_transfer_tb.sv
